// File: rtl/mtug_pkg.sv
package mtug_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned IDX_W       = 10;
	localparam int unsigned STATE_WORDS = 624;
	localparam int unsigned SHIFT_OFF   = 397;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] SHIFT_IDX = IDX_W'(SHIFT_OFF);
	localparam logic [IDX_W-1:0] WRAP_IDX  = IDX_W'(STATE_WORDS - SHIFT_OFF);
	localparam logic [IDX_W-1:0] MAX_TRIES = IDX_W'(STATE_WORDS);

	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
	localparam logic [WORD_W-1:0] LCG_MUL      = 32'd69069;
	localparam logic [WORD_W-1:0] TWIST_CONST  = 32'h9908b0df;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

	// Command queue between the front and back parts.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	typedef struct packed {
		logic              do_seed;
		logic [WORD_W-1:0] seed;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] prod;
		prod = s * LCG_MUL;
		return prod + 32'd1;
	endfunction

	// New word from the top bit of word k, the low bits of word k+1 and word k+397.
	function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt, input logic [WORD_W-1:0] far);
		logic [WORD_W-1:0] y;
		y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
		return far ^ (y >> 1) ^ (y[0] ? TWIST_CONST : '0);
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: rtl/mersenne_twister_uniform_generator.sv
// Channel      Signals                       Direction  Handshake
// request      start, restart, busy          in / out   taken when start=1 and busy=0
// seed config  seed_we, seed_value           in         written when seed_we=1
// result       done, fraction                out        one-cycle strobe, no back-pressure
//
// A plain draw goes through the back part as a queue pop, then a step in which the single
// write port table is read at the next word and the far word, then a step that twists,
// writes back and tempers. A seeding item first fills every table word from the upper
// halves of two successive LCG values. A zero word repeats the read and twist steps.
// Reset clears the control state and loads the seed register with 4357; the table has
// no reset and is filled by the first item. busy is high only while the two-entry
// command queue is full; the receiver cannot stall, so results leave as they finish.
module mersenne_twister_uniform_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             restart,
	output logic                             busy,
	input  logic                             seed_we,
	input  logic [mtug_pkg::WORD_W-1:0]      seed_value,
	output logic                             done,
	output logic [mtug_pkg::WORD_W-1:0]      fraction
);

	logic [mtug_pkg::WORD_W-1:0] seed_q;
	mtug_pkg::qstat_t             qstat;
	mtug_pkg::cmd_t               push_cmd;
	mtug_pkg::cmd_t               pop_cmd;
	logic                         push;
	logic                         pop;

	// The seed register is only read when an item is taken, so a new seed takes
	// effect at the next restart or at the very first item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= mtug_pkg::DEFAULT_SEED;
		end else if (seed_we) begin
			seed_q <= seed_value;
		end
	end

	assign busy = qstat.full;

	// The front part decides per item whether the table must be filled first.
	mtug_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.restart   (restart),
		.seed_word (seed_q),
		.qstat     (qstat),
		.push      (push),
		.cmd       (push_cmd)
	);

	mtug_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	// The back part owns the state table, seeds it and twists one word per draw, and one more for each zero word.
	mtug_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.cmd      (pop_cmd),
		.pop      (pop),
		.done     (done),
		.fraction (fraction)
	);

endmodule

// File: rtl/mtug_front.sv
module mtug_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             restart,
	input  logic [mtug_pkg::WORD_W-1:0]      seed_word,
	input  mtug_pkg::qstat_t                 qstat,
	output logic                             push,
	output mtug_pkg::cmd_t                   cmd
);

	logic seeded_q;

	assign push        = start & ~qstat.full;
	// An item reseeds when it asks for it or when the table was never filled.
	assign cmd.do_seed = restart | ~seeded_q;
	assign cmd.seed    = seed_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
		end else if (push) begin
			seeded_q <= 1'b1;
		end
	end

endmodule

// File: rtl/mtug_fifo.sv
module mtug_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mtug_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output mtug_pkg::cmd_t   pop_cmd,
	output mtug_pkg::qstat_t qstat
);

	mtug_pkg::cmd_t                  slot_q [mtug_pkg::QDEPTH];
	logic [mtug_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mtug_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mtug_pkg::QCNT_W-1:0]     count_q;

	assign qstat.full  = (count_q == mtug_pkg::QCNT_W'(mtug_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/mtug_back.sv
module mtug_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mtug_pkg::qstat_t             qstat,
	input  mtug_pkg::cmd_t               cmd,
	output logic                         pop,
	output logic                         done,
	output logic [mtug_pkg::WORD_W-1:0]  fraction
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FILL_A = 3'd1;
	localparam logic [2:0] S_FILL_B = 3'd2;
	localparam logic [2:0] S_RD     = 3'd3;
	localparam logic [2:0] S_TW     = 3'd4;

	logic [2:0]                        state_q;
	logic [mtug_pkg::WORD_W-1:0]       mem [mtug_pkg::STATE_WORDS];
	logic [mtug_pkg::WORD_W-1:0]       rd_a_q;
	logic [mtug_pkg::WORD_W-1:0]       rd_b_q;
	logic [mtug_pkg::IDX_W-1:0]        rd_a_addr;
	logic [mtug_pkg::IDX_W-1:0]        rd_b_addr;
	logic                              mem_we;
	logic [mtug_pkg::IDX_W-1:0]        mem_wa;
	logic [mtug_pkg::WORD_W-1:0]       mem_wd;

	logic [mtug_pkg::WORD_W-1:0]       lcg_q;
	logic [15:0]                       hi_q;
	logic [mtug_pkg::IDX_W-1:0]        fill_idx_q;
	logic [mtug_pkg::IDX_W-1:0]        ptr_q;
	logic [mtug_pkg::IDX_W-1:0]        ptr_nxt;
	logic [mtug_pkg::IDX_W-1:0]        tries_q;
	logic [mtug_pkg::WORD_W-1:0]       cur_q;
	logic [mtug_pkg::WORD_W-1:0]       fill_word;
	logic [mtug_pkg::WORD_W-1:0]       new_word;
	logic [mtug_pkg::WORD_W-1:0]       tempered;
	logic                              done_q;
	logic [mtug_pkg::WORD_W-1:0]       result_q;

	assign pop       = (state_q == S_IDLE) & ~qstat.empty;
	assign done      = done_q;
	assign fraction  = result_q;

	assign ptr_nxt   = (ptr_q == mtug_pkg::LAST_IDX) ? '0 : ptr_q + 1'b1;
	assign rd_a_addr = ptr_nxt;
	assign rd_b_addr = (ptr_q >= mtug_pkg::WRAP_IDX) ? ptr_q - mtug_pkg::WRAP_IDX
	                                                 : ptr_q + mtug_pkg::SHIFT_IDX;

	assign fill_word = {hi_q, lcg_q[31:16]};
	assign new_word  = mtug_pkg::twist_word(cur_q, rd_a_q, rd_b_q);
	assign tempered  = mtug_pkg::temper(new_word);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = new_word;
		case (state_q)
			S_FILL_B: begin
				mem_we = 1'b1;
				mem_wa = fill_idx_q;
				mem_wd = fill_word;
			end
			S_TW: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	// The word at the draw pointer is kept in a register, so each draw
	// needs only the next word and the far word from the table.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lcg_q <= cmd.seed;
			end
			S_FILL_A: begin
				hi_q  <= lcg_q[31:16];
				lcg_q <= mtug_pkg::lcg_next(lcg_q);
			end
			S_FILL_B: begin
				lcg_q <= mtug_pkg::lcg_next(lcg_q);
				if (fill_idx_q == '0) begin
					cur_q <= fill_word;
				end
			end
			S_TW: begin
				cur_q <= rd_a_q;
				result_q <= (tempered != '0) ? tempered : mtug_pkg::WORD_W'(1);
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_idx_q <= '0;
			ptr_q      <= '0;
			tries_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					tries_q <= '0;
					if (pop) begin
						if (cmd.do_seed) begin
							fill_idx_q <= '0;
							state_q    <= S_FILL_A;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_FILL_A: begin
					state_q <= S_FILL_B;
				end
				S_FILL_B: begin
					fill_idx_q <= fill_idx_q + 1'b1;
					if (fill_idx_q == mtug_pkg::LAST_IDX) begin
						ptr_q   <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_FILL_A;
					end
				end
				S_RD: begin
					state_q <= S_TW;
				end
				S_TW: begin
					ptr_q <= ptr_nxt;
					if (tempered != '0 || tries_q == mtug_pkg::MAX_TRIES) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						tries_q <= tries_q + 1'b1;
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/mtug_checker.sv
module mtug_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             done,
	input  logic [mtug_pkg::WORD_W-1:0]      fraction
);

	logic [2:0] outstanding_q;
	logic       accept;

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({accept, done})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outstanding_q != 3'd0)
		else $error("result without an outstanding item");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> outstanding_q >= 3'd2)
		else $error("busy while fewer than two items are queued");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd3)
		else $error("more items in flight than the design holds");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fraction != '0)
		else $error("zero fraction delivered");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on adjacent cycles");

endmodule

bind mersenne_twister_uniform_generator mtug_checker u_mtug_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.fraction (fraction)
);

// File: dv/tb_mersenne_twister_uniform_generator.sv
`timescale 1ns / 100ps

module tb_mersenne_twister_uniform_generator;

	// Generator constants, kept apart from the package so that a wrong constant in
	// the design cannot hide behind the same wrong value here.
	localparam int unsigned TABLE_DEPTH  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam logic [31:0] RESET_SEED   = 32'd4357;
	localparam logic [31:0] LCG_MULT     = 32'd69069;
	localparam logic [31:0] UPPER_HALF   = 32'hffff0000;
	localparam logic [31:0] TWIST_MAT    = 32'h9908b0df;
	localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_MASK_C = 32'hefc60000;

	// A seeding item alone keeps the block quiet while it fills the whole table, and two of
	// them can sit in the command queue, so the quiet limit leaves a wide margin.
	localparam int unsigned WATCHDOG_LIMIT = 8000;
	localparam int unsigned DRAIN_CYCLES   = 20;

	// Tracks the generator: its own seed register, table and read pointer, and the
	// fractions that accepted items still owe.
	class mt19937_draws;
		logic [31:0] seed_reg;
		logic [31:0] mt_table [TABLE_DEPTH];
		int unsigned next_word;
		bit          table_seeded;
		logic [31:0] due_fractions [$];
		int unsigned error_count;

		function new();
			seed_reg     = RESET_SEED;
			next_word    = TABLE_DEPTH;
			table_seeded = 1'b0;
			error_count  = 0;
		endfunction

		function void set_seed(logic [31:0] value);
			seed_reg = value;
		endfunction

		// Called for every accepted item: reseeds when asked (or on the very first
		// item), then draws tempered words until one is nonzero.
		function void note_draw(bit reseed);
			logic [31:0] s;
			logic [31:0] hi;
			logic [31:0] y;
			int unsigned k;
			int unsigned tries;
			if (reseed || !table_seeded) begin
				s = seed_reg;
				for (k = 0; k < TABLE_DEPTH; k++) begin
					hi = s & UPPER_HALF;
					s = s * LCG_MULT + 32'd1;
					mt_table[k] = hi | (s >> 16);
					s = s * LCG_MULT + 32'd1;
				end
				next_word    = TABLE_DEPTH;
				table_seeded = 1'b1;
			end
			y = '0;
			for (tries = 0; tries <= TABLE_DEPTH && y == '0; tries++) begin
				if (next_word >= TABLE_DEPTH) begin
					// Whole-table twist; words past the wrap point already see
					// their freshly twisted partners, as in the incremental form.
					for (k = 0; k < TABLE_DEPTH; k++) begin
						y = {mt_table[k][31], mt_table[(k + 1) % TABLE_DEPTH][30:0]};
						mt_table[k] = mt_table[(k + TWIST_OFFSET) % TABLE_DEPTH] ^
							(y >> 1) ^ (y[0] ? TWIST_MAT : 32'd0);
					end
					next_word = 0;
				end
				y = mt_table[next_word];
				next_word++;
				y = y ^ (y >> 11);
				y = y ^ ((y << 7) & TEMPER_MASK_B);
				y = y ^ ((y << 15) & TEMPER_MASK_C);
				y = y ^ (y >> 18);
			end
			if (y == '0) begin
				y = 32'd1;
			end
			due_fractions.push_back(y);
		endfunction

		function void check_fraction(logic [31:0] got);
			logic [31:0] want;
			if (due_fractions.size() == 0) begin
				$error("fraction: result with no item waiting, actual %h", got);
				error_count++;
			end else begin
				want = due_fractions.pop_front();
				if (got !== want) begin
					$error("fraction mismatch: expected %h, actual %h", want, got);
					error_count++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic restart = 1'b0;
	logic busy;
	logic seed_we = 1'b0;
	logic [mtug_pkg::WORD_W-1:0] seed_value = '0;
	logic done;
	logic [mtug_pkg::WORD_W-1:0] fraction;

	mt19937_draws draws = new();
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	mersenne_twister_uniform_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.restart    (restart),
		.busy       (busy),
		.seed_we    (seed_we),
		.seed_value (seed_value),
		.done       (done),
		.fraction   (fraction)
	);

	// Results cannot be held off, so every strobe is checked at the edge that
	// ends its cycle. Outputs are read before the design's updates for that edge
	// land, which keeps the check independent of process order.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			draws.check_fraction(fraction);
		end
	end

	// The watchdog restarts its count on every accepted item and every result.
	// Long stretches with neither mean the design has hung.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Presents one item and holds it until the block takes it. When the next item
	// follows at once, start simply stays high; otherwise it drops for the gap and
	// restart carries random noise that the block must ignore.
	task automatic send_draw(bit reseed, int unsigned gap);
		start <= 1'b1;
		restart <= reseed;
		do @(posedge clk); while (busy !== 1'b0);
		draws.note_draw(reseed);
		if (gap > 0) begin
			start <= 1'b0;
			restart <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits for every owed fraction. The design has one result
	// per item, so once the last one is out the block is idle.
	task automatic wait_idle();
		start <= 1'b0;
		while (draws.due_fractions.size() != 0) @(posedge clk);
	endtask

	// The seed register is only written while nothing is in flight.
	task automatic write_seed(logic [31:0] value);
		seed_we <= 1'b1;
		seed_value <= value;
		@(posedge clk);
		seed_we <= 1'b0;
		draws.set_seed(value);
	endtask

	initial begin
		int unsigned phase_len [4];
		int unsigned p;
		int unsigned i;
		int unsigned gap;
		int unsigned burst_left;
		bit reseed;

		phase_len = '{700, 300, 250, 500};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The very first item seeds from the reset seed even without a restart
		// request. A few plain draws follow, then a restart and more draws.
		send_draw(1'b0, pick_gap());
		send_draw(1'b0, 0);
		send_draw(1'b0, 0);
		send_draw(1'b0, pick_gap());
		send_draw(1'b1, pick_gap());
		send_draw(1'b0, 0);
		send_draw(1'b0, pick_gap());

		// Writing the seed must not reseed by itself: the next draws continue
		// the old table until a restart picks up the all-zero seed.
		wait_idle();
		write_seed(32'h0000_0000);
		send_draw(1'b0, 0);
		send_draw(1'b0, pick_gap());
		send_draw(1'b1, 0);
		send_draw(1'b0, 0);
		send_draw(1'b0, pick_gap());

		// All-ones seed, with two restarts back to back.
		wait_idle();
		write_seed(32'hffff_ffff);
		send_draw(1'b1, 0);
		send_draw(1'b1, 0);
		send_draw(1'b0, pick_gap());
		send_draw(1'b0, 0);
		send_draw(1'b0, pick_gap());

		wait_idle();
		write_seed($urandom);
		send_draw(1'b1, pick_gap());
		send_draw(1'b0, pick_gap());

		// Random phases. The first runs long without restarts so that the table
		// wraps and twists; later phases vary how often a reseed is asked for.
		// Each phase starts from an idle block with a fresh seed.
		for (p = 0; p < 4; p++) begin
			wait_idle();
			write_seed((p == 3) ? 32'($urandom_range(0, 15)) : $urandom);
			burst_left = 0;
			for (i = 0; i < phase_len[p]; i++) begin
				case (p)
					1: begin
						reseed = ($urandom_range(0, 149) == 0);
					end
					2: begin
						reseed = (i == 0) || ($urandom_range(0, 14) == 0);
					end
					default: begin
						reseed = 1'b0;
					end
				endcase
				// Occasional bursts with no gaps at all keep the command
				// queue full and busy high for a while.
				if (burst_left > 0) begin
					gap = 0;
					burst_left--;
				end else begin
					if ($urandom_range(0, 29) == 0) begin
						burst_left = $urandom_range(20, 80);
					end
					gap = pick_gap();
				end
				send_draw(reseed, gap);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (draws.error_count == 0 && draws.due_fractions.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/mtug_pkg.sv
rtl/mtug_front.sv
rtl/mtug_fifo.sv
rtl/mtug_back.sv
rtl/mersenne_twister_uniform_generator.sv
rtl/mtug_checker.sv
dv/tb_mersenne_twister_uniform_generator.sv
